// ===== design/grain_grid_gravity_step_top_defines.svh =====
// Assertion macros shared by the grain board checker.
`ifndef GRAIN_GRID_GRAVITY_STEP_TOP_DEFINES_SVH
`define GRAIN_GRID_GRAVITY_STEP_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define GGS_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define GGS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/ggs_pkg.sv =====
// Types, codes and direction tables for the grain board block.
package ggs_pkg;

  localparam int unsigned SIDE_CAP = 16;
  localparam int unsigned CELLS    = 256;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_SPARE  = 2'd3;

  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_FELL = 3'd1;
  localparam logic [2:0] ST_SLID = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;

  localparam logic CFG_BOARD = 1'b0;
  localparam logic CFG_GRAV  = 1'b1;

  localparam logic [4:0] BOARD_RST = 5'd8;
  localparam logic [2:0] GRAV_RST  = 3'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] grain_vert;
    logic [3:0] grain_horiz;
    logic       rand_bit;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] from_vert;
    logic [3:0] from_horiz;
    logic [3:0] to_vert;
    logic [3:0] to_horiz;
    logic [8:0] grain_count;
  } out_item_t;

  typedef struct packed {
    logic [3:0] vert;
    logic [3:0] horiz;
  } pos_t;

  typedef struct packed {
    logic on_board;
    pos_t spot;
  } target_t;

  typedef enum logic [1:0] {PH_GRAV, PH_SIDE_A, PH_SIDE_B} phase_e;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_APP_RD, S_APP_WR, S_FETCH, S_LATCH, S_AIM, S_TEST,
    S_SHIFT_RD, S_SHIFT_WR, S_PLACE, S_FROM_RD, S_FROM_WR, S_TO_RD, S_TO_WR,
    S_DONE
  } state_e;

  // Vertical step: up is -1.
  function automatic logic signed [1:0] dir_dv(logic [2:0] d);
    logic signed [1:0] r;
    unique case (d)
      3'd0, 3'd1, 3'd7: r = -2'sd1;
      3'd2, 3'd6:       r = 2'sd0;
      default:          r = 2'sd1;
    endcase
    return r;
  endfunction

  // Horizontal step: left is -1.
  function automatic logic signed [1:0] dir_dh(logic [2:0] d);
    logic signed [1:0] r;
    unique case (d)
      3'd1, 3'd2, 3'd3: r = 2'sd1;
      3'd0, 3'd4:       r = 2'sd0;
      default:          r = -2'sd1;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] side_a(logic [2:0] d);
    logic [2:0] r;
    unique case (d)
      3'd0:    r = 3'd7;
      3'd1:    r = 3'd0;
      3'd2:    r = 3'd1;
      3'd3:    r = 3'd4;
      3'd4:    r = 3'd5;
      3'd5:    r = 3'd4;
      3'd6:    r = 3'd7;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] side_b(logic [2:0] d);
    logic [2:0] r;
    unique case (d)
      3'd0:    r = 3'd1;
      3'd1:    r = 3'd2;
      3'd2:    r = 3'd3;
      3'd3:    r = 3'd2;
      3'd4:    r = 3'd3;
      3'd5:    r = 3'd6;
      3'd6:    r = 3'd5;
      default: r = 3'd6;
    endcase
    return r;
  endfunction

endpackage

// ===== design/ggs_aim.sv =====
// Neighbor cell of a grain in one direction, with the inside-board test.
module ggs_aim (
  input  ggs_pkg::pos_t    grain_i,
  input  logic [2:0]       dir_i,
  input  logic [4:0]       board_size_i,
  output ggs_pkg::target_t target_o
);

  logic [4:0]        lim;
  logic signed [1:0] dv, dh;
  logic signed [5:0] v, h;

  always_comb begin
    lim = (board_size_i > 5'(ggs_pkg::SIDE_CAP)) ? 5'(ggs_pkg::SIDE_CAP) : board_size_i;
    dv  = ggs_pkg::dir_dv(dir_i);
    dh  = ggs_pkg::dir_dh(dir_i);
    v   = $signed({2'b00, grain_i.vert}) + $signed({{4{dv[1]}}, dv});
    h   = $signed({2'b00, grain_i.horiz}) + $signed({{4{dh[1]}}, dh});
    target_o.on_board   = !v[5] && !h[5] && (v[4:0] < lim) && (h[4:0] < lim);
    target_o.spot.vert  = v[3:0];
    target_o.spot.horiz = h[3:0];
  end

endmodule

// ===== design/grain_grid_gravity_step_top.sv =====
// Grain board top level: list memory, cell count memory and the tick sequencer.
// Clear zeroes the cell counts; append adds a list entry and bumps its cell count; a tick
// scans gravity, then both sides, and moves the first grain that can fall, else slide, to the list end.
// Throughput: one item at a time; the sequencer and the one-read, one-write memories set it.
// Reset: list empty, board 8, gravity DR; a sweep then zeroes all 256 cells of the
// cell count memory, during which no item is taken (config writes still land).
module grain_grid_gravity_step_top #(
  parameter int unsigned MAX_GRAINS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ggs_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ggs_pkg::out_item_t   out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [4:0]           cfg_data_i
);

  localparam int unsigned IW = (MAX_GRAINS > 1) ? $clog2(MAX_GRAINS) : 1;
  localparam int unsigned LW = $clog2(MAX_GRAINS + 1);

  ggs_pkg::state_e   state_q, state_d;
  ggs_pkg::phase_e   phase_q, phase_d;
  logic [4:0]        board_q;
  logic [2:0]        grav_q;
  logic [LW-1:0]     len_q, len_d;
  logic [IW-1:0]     idx_q, idx_d, j_q, j_d;
  logic [7:0]        clr_q, clr_d;
  logic              init_q, init_d;
  ggs_pkg::in_item_t req_q, req_d;
  ggs_pkg::pos_t     grain_q, grain_d, tgt_a_q, tgt_a_d, from_q, from_d, to_q, to_d;
  ggs_pkg::target_t  tgt_q, tgt_d, aim;
  logic              free_a_q, free_a_d;
  logic [2:0]        status_q, status_d;
  logic              out_valid_q, out_valid_d;
  ggs_pkg::out_item_t out_q, out_d;

  // List memory: grain positions in list order.
  ggs_pkg::pos_t list_mem [MAX_GRAINS];
  logic          list_we;
  logic [IW-1:0] list_waddr, list_raddr;
  ggs_pkg::pos_t list_wdata, list_rdata_q;

  // Cell count memory: how many list entries sit on each cell.
  logic [LW-1:0] cnt_mem [ggs_pkg::CELLS];
  logic          cnt_we;
  logic [7:0]    cnt_waddr, cnt_raddr;
  logic [LW-1:0] cnt_wdata, cnt_rdata_q;

  logic [2:0] aim_dir;
  logic       free, more, take_b;

  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    list_rdata_q <= list_mem[list_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata_q <= cnt_mem[cnt_raddr];
  end

  // Direction for this scan step: gravity, then the two sides.
  always_comb begin
    unique case (phase_q)
      ggs_pkg::PH_GRAV:   aim_dir = grav_q;
      ggs_pkg::PH_SIDE_A: aim_dir = ggs_pkg::side_a(grav_q);
      default:            aim_dir = ggs_pkg::side_b(grav_q);
    endcase
  end

  ggs_aim u_aim (
    .grain_i      (grain_q),
    .dir_i        (aim_dir),
    .board_size_i (board_q),
    .target_o     (aim)
  );

  assign free   = tgt_q.on_board && (cnt_rdata_q == '0);
  assign more   = (LW'(idx_q) + LW'(1)) < len_q;
  // Both sides free: rand bit picks; otherwise the free one.
  assign take_b = (free_a_q && free) ? req_q.rand_bit : free;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ggs_pkg::S_CLR:
        if (clr_q == 8'hff) state_d = init_q ? ggs_pkg::S_IDLE : ggs_pkg::S_DONE;
      ggs_pkg::S_IDLE:
        if (in_valid_i) begin
          priority case (in_data_i.req_type)
            ggs_pkg::REQ_CLEAR:  state_d = ggs_pkg::S_CLR;
            ggs_pkg::REQ_APPEND: state_d = (len_q >= LW'(MAX_GRAINS)) ? ggs_pkg::S_DONE
                                                                     : ggs_pkg::S_APP_RD;
            ggs_pkg::REQ_TICK:   state_d = (len_q == '0) ? ggs_pkg::S_DONE : ggs_pkg::S_FETCH;
            default:             state_d = ggs_pkg::S_DONE;
          endcase
        end
      ggs_pkg::S_APP_RD:   state_d = ggs_pkg::S_APP_WR;
      ggs_pkg::S_APP_WR:   state_d = ggs_pkg::S_DONE;
      ggs_pkg::S_FETCH:    state_d = ggs_pkg::S_LATCH;
      ggs_pkg::S_LATCH:    state_d = ggs_pkg::S_AIM;
      ggs_pkg::S_AIM:      state_d = ggs_pkg::S_TEST;
      ggs_pkg::S_TEST: begin
        priority if (phase_q == ggs_pkg::PH_SIDE_A) begin
          state_d = ggs_pkg::S_AIM;
        end else if (free || (phase_q == ggs_pkg::PH_SIDE_B && free_a_q)) begin
          state_d = more ? ggs_pkg::S_SHIFT_RD : ggs_pkg::S_PLACE;
        end else if (phase_q == ggs_pkg::PH_GRAV || more) begin
          state_d = ggs_pkg::S_FETCH;
        end else begin
          state_d = ggs_pkg::S_DONE;
        end
      end
      ggs_pkg::S_SHIFT_RD: state_d = ggs_pkg::S_SHIFT_WR;
      ggs_pkg::S_SHIFT_WR:
        state_d = ((LW'(j_q) + LW'(2)) < len_q) ? ggs_pkg::S_SHIFT_RD : ggs_pkg::S_PLACE;
      ggs_pkg::S_PLACE:    state_d = ggs_pkg::S_FROM_RD;
      ggs_pkg::S_FROM_RD:  state_d = ggs_pkg::S_FROM_WR;
      ggs_pkg::S_FROM_WR:  state_d = ggs_pkg::S_TO_RD;
      ggs_pkg::S_TO_RD:    state_d = ggs_pkg::S_TO_WR;
      ggs_pkg::S_TO_WR:    state_d = ggs_pkg::S_DONE;
      ggs_pkg::S_DONE:
        if (!out_valid_q || out_ready_i) state_d = ggs_pkg::S_IDLE;
      default:             state_d = ggs_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory controls and result register.
  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    idx_d       = idx_q;
    j_d         = j_q;
    clr_d       = clr_q;
    init_d      = init_q;
    req_d       = req_q;
    grain_d     = grain_q;
    tgt_d       = tgt_q;
    tgt_a_d     = tgt_a_q;
    free_a_d    = free_a_q;
    from_d      = from_q;
    to_d        = to_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    list_we     = 1'b0;
    list_waddr  = j_q;
    list_wdata  = list_rdata_q;
    list_raddr  = idx_q;
    cnt_we      = 1'b0;
    cnt_waddr   = from_q;
    cnt_wdata   = cnt_rdata_q - LW'(1);
    cnt_raddr   = from_q;

    unique case (state_q)
      ggs_pkg::S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        cnt_wdata = '0;
        clr_d     = clr_q + 8'd1;
        if (clr_q == 8'hff) init_d = 1'b0;
      end
      ggs_pkg::S_IDLE:
        if (in_valid_i) begin
          req_d    = in_data_i;
          idx_d    = '0;
          phase_d  = ggs_pkg::PH_GRAV;
          clr_d    = '0;
          from_d   = '0;
          to_d     = '0;
          status_d = ggs_pkg::ST_NONE;
          if (in_data_i.req_type == ggs_pkg::REQ_CLEAR) len_d = '0;
          if (in_data_i.req_type == ggs_pkg::REQ_APPEND && len_q >= LW'(MAX_GRAINS))
            status_d = ggs_pkg::ST_FULL;
        end
      ggs_pkg::S_APP_RD: begin
        cnt_raddr  = {req_q.grain_vert, req_q.grain_horiz};
        list_we    = 1'b1;
        list_waddr = IW'(len_q);
        list_wdata = {req_q.grain_vert, req_q.grain_horiz};
      end
      ggs_pkg::S_APP_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = {req_q.grain_vert, req_q.grain_horiz};
        cnt_wdata = cnt_rdata_q + LW'(1);
        len_d     = len_q + LW'(1);
      end
      ggs_pkg::S_FETCH:    list_raddr = idx_q;
      ggs_pkg::S_LATCH:    grain_d = list_rdata_q;
      ggs_pkg::S_AIM: begin
        tgt_d     = aim;
        cnt_raddr = aim.spot;
      end
      ggs_pkg::S_TEST:
        unique case (phase_q)
          ggs_pkg::PH_GRAV:
            if (free) begin
              from_d   = grain_q;
              to_d     = tgt_q.spot;
              status_d = ggs_pkg::ST_FELL;
              j_d      = idx_q;
            end else if (more) begin
              idx_d = idx_q + IW'(1);
            end else begin
              idx_d   = '0;
              phase_d = ggs_pkg::PH_SIDE_A;
            end
          ggs_pkg::PH_SIDE_A: begin
            free_a_d = free;
            tgt_a_d  = tgt_q.spot;
            phase_d  = ggs_pkg::PH_SIDE_B;
          end
          default:
            if (free || free_a_q) begin
              from_d   = grain_q;
              to_d     = take_b ? tgt_q.spot : tgt_a_q;
              status_d = ggs_pkg::ST_SLID;
              j_d      = idx_q;
            end else if (more) begin
              idx_d   = idx_q + IW'(1);
              phase_d = ggs_pkg::PH_SIDE_A;
            end
        endcase
      ggs_pkg::S_SHIFT_RD: list_raddr = j_q + IW'(1);
      ggs_pkg::S_SHIFT_WR: begin
        list_we    = 1'b1;
        list_waddr = j_q;
        list_wdata = list_rdata_q;
        j_d        = j_q + IW'(1);
      end
      ggs_pkg::S_PLACE: begin
        list_we    = 1'b1;
        list_waddr = IW'(len_q - LW'(1));
        list_wdata = to_q;
      end
      ggs_pkg::S_FROM_RD:  cnt_raddr = from_q;
      ggs_pkg::S_FROM_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = from_q;
        cnt_wdata = cnt_rdata_q - LW'(1);
      end
      ggs_pkg::S_TO_RD:    cnt_raddr = to_q;
      ggs_pkg::S_TO_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = to_q;
        cnt_wdata = cnt_rdata_q + LW'(1);
      end
      ggs_pkg::S_DONE:
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.status      = status_q;
          out_d.from_vert   = from_q.vert;
          out_d.from_horiz  = from_q.horiz;
          out_d.to_vert     = to_q.vert;
          out_d.to_horiz    = to_q.horiz;
          out_d.grain_count = 9'(len_q);
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ggs_pkg::S_CLR;
      phase_q     <= ggs_pkg::PH_GRAV;
      len_q       <= '0;
      idx_q       <= '0;
      j_q         <= '0;
      clr_q       <= '0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      j_q         <= j_d;
      clr_q       <= clr_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    grain_q  <= grain_d;
    tgt_q    <= tgt_d;
    tgt_a_q  <= tgt_a_d;
    free_a_q <= free_a_d;
    from_q   <= from_d;
    to_q     <= to_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  // Config registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_q <= ggs_pkg::BOARD_RST;
      grav_q  <= ggs_pkg::GRAV_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ggs_pkg::CFG_BOARD) board_q <= cfg_data_i;
      if (cfg_idx_i == ggs_pkg::CFG_GRAV)  grav_q  <= cfg_data_i[2:0];
    end
  end

  assign in_ready_o  = (state_q == ggs_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/ggs_checker.sv =====
// Port-level checks for the grain board top level, bound into it.
`include "grain_grid_gravity_step_top_defines.svh"

module ggs_checker #(
  parameter int unsigned MAX_GRAINS = 256
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ggs_pkg::out_item_t out_data_o
);

  `GGS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")

  `GGS_ASSERT_NEXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o, "input taken again while item in flight")

  `GGS_ASSERT_NOW(a_status_code, out_valid_o, out_data_o.status <= ggs_pkg::ST_FULL, "unknown status code")

  `GGS_ASSERT_NOW(a_full_count, out_valid_o && out_data_o.status == ggs_pkg::ST_FULL, out_data_o.grain_count == 9'(MAX_GRAINS), "rejected append with list not full")

endmodule

bind grain_grid_gravity_step_top ggs_checker #(.MAX_GRAINS(MAX_GRAINS)) u_ggs_checker (.*);
